[src/crash_particle_physics_step_core_defines.svh]
// Assertion macros used by the checker file of the particle step core.
`ifndef CRASH_PARTICLE_PHYSICS_STEP_CORE_DEFINES_SVH
`define CRASH_PARTICLE_PHYSICS_STEP_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/cps_pkg.sv]
// Types, constants and helper functions of the debris particle step core.
package cps_pkg;

  // Default coordinate width of the stored position
  localparam int CPS_COORD_BITS = 16;

  // Configuration register reset values
  localparam logic [15:0] CPS_GRAVITY_RESET    = 16'd5041;
  localparam logic [11:0] CPS_FRAME_STEP_RESET = 12'd85;
  localparam logic [11:0] CPS_FRAME_LIM_RESET  = 12'd3072;
  localparam logic [7:0]  CPS_LIFE_BASE_RESET  = 8'd140;

  // Spawn seeding constants
  localparam logic [31:0] CPS_SPAWN_LIFT = 32'h0001_0000;
  localparam logic [11:0] CPS_FRAME_MUL  = 12'd12;
  localparam logic [10:0] CPS_VARIANT_MUL = 11'd5;

  localparam int CPS_CFG_IDX_BITS  = 2;
  localparam int CPS_CFG_DATA_BITS = 16;

  typedef enum logic [CPS_CFG_IDX_BITS-1:0] {
    CFG_GRAVITY_STEP = 2'd0,
    CFG_FRAME_STEP   = 2'd1,
    CFG_FRAME_LIMIT  = 2'd2,
    CFG_LIFE_BASE    = 2'd3
  } cps_cfg_idx_t;

  typedef enum logic {
    OP_SPAWN = 1'b0,
    OP_TICK  = 1'b1
  } cps_op_t;

  typedef struct packed {
    logic [15:0] gravity_step;
    logic [11:0] frame_step;
    logic [11:0] frame_limit;
    logic [7:0]  life_base;
  } cps_cfg_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] spawn_x;
    logic [15:0] spawn_y;
    logic [15:0] spawn_z;
    logic [31:0] random_word;
    logic [14:0] land_height;
    logic [14:0] water_height;
  } cps_item_t;

  typedef struct packed {
    logic        alive;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [11:0] anim_frame;
    logic [2:0]  sprite_variant;
    logic        splashed;
  } cps_result_t;

  // Drag: speed minus speed/256, quotient truncated toward zero.
  function automatic logic [31:0] cps_drag(input logic [31:0] s);
    logic [31:0] q;
    q = {{8{s[31]}}, s[31:8]} + {31'b0, (s[31] && (s[7:0] != 8'd0))};
    return s - q;
  endfunction

endpackage

[src/cps_axis_step.sv]
// One axis of motion: drag on the speed, then 16.16 accumulation into position.
module cps_axis_step #(
  parameter int COORD_BITS = cps_pkg::CPS_COORD_BITS
) (
  input  logic [COORD_BITS-1:0] pos_in,
  input  logic [31:0]           speed_in,
  input  logic [15:0]           frac_in,
  output logic [COORD_BITS-1:0] pos_out,
  output logic [31:0]           speed_out,
  output logic [15:0]           frac_out
);
  import cps_pkg::*;

  logic [31:0]           sum;
  logic [COORD_BITS-1:0] step;

  // Stored fraction is reused as a signed 16-bit value
  assign speed_out = cps_drag(speed_in);
  assign sum       = {{16{frac_in[15]}}, frac_in} + speed_out;
  assign step      = COORD_BITS'($signed(sum[31:16]));
  assign pos_out   = pos_in + step;
  assign frac_out  = sum[15:0];

endmodule

[src/cps_cfg_regs.sv]
// Configuration register file of the particle step core.
module cps_cfg_regs (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic [cps_pkg::CPS_CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [cps_pkg::CPS_CFG_DATA_BITS-1:0]  cfg_data,
  output logic                                   cfg_ready,
  output cps_pkg::cps_cfg_t                      cfg
);
  import cps_pkg::*;

  // Writes are registered directly, so the port is always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity_step <= CPS_GRAVITY_RESET;
      cfg.frame_step   <= CPS_FRAME_STEP_RESET;
      cfg.frame_limit  <= CPS_FRAME_LIM_RESET;
      cfg.life_base    <= CPS_LIFE_BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRAVITY_STEP: cfg.gravity_step <= cfg_data;
        CFG_FRAME_STEP:   cfg.frame_step   <= cfg_data[11:0];
        CFG_FRAME_LIMIT:  cfg.frame_limit  <= cfg_data[11:0];
        CFG_LIFE_BASE:    cfg.life_base    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[src/cps_update.sv]
// Particle state registers and the per-item spawn / tick update.
module cps_update #(
  parameter int COORD_BITS = cps_pkg::CPS_COORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  cps_pkg::cps_item_t     item,
  input  cps_pkg::cps_cfg_t      cfg,
  output cps_pkg::cps_result_t   result,
  output logic [COORD_BITS-1:0]  position_x,
  output logic [COORD_BITS-1:0]  position_y,
  output logic [31:0]            speed_x,
  output logic [31:0]            speed_y,
  output logic [15:0]            fraction_x,
  output logic [15:0]            fraction_y
);
  import cps_pkg::*;

  logic                  live_flag, live_flag_next;
  logic [COORD_BITS-1:0] position_z;
  logic [COORD_BITS-1:0] position_x_next, position_y_next, position_z_next;
  logic [31:0]           speed_z;
  logic [31:0]           speed_x_next, speed_y_next, speed_z_next;
  logic [15:0]           fraction_z;
  logic [15:0]           fraction_x_next, fraction_y_next, fraction_z_next;
  logic [8:0]            lifetime, lifetime_next;
  logic [11:0]           anim_counter, anim_counter_next;
  logic [2:0]            variant, variant_next;

  logic [8:0]            life_dec;
  logic [31:0]           speed_z_grav;
  logic [COORD_BITS-1:0] nx, ny, nz;
  logic [31:0]           dsx, dsy, dsz;
  logic [15:0]           fx, fy, fz;
  logic [COORD_BITS-1:0] land_ext, water_ext;
  logic                  splash, bounce;
  logic [12:0]           anim_sum;
  logic [11:0]           anim_adv;
  logic [11:0]           spawn_anim;
  logic [10:0]           spawn_vprod;
  logic [COORD_BITS-1:0] spawn_px, spawn_py, spawn_pz;

  // Three axes of motion
  assign speed_z_grav = speed_z - {16'b0, cfg.gravity_step};

  cps_axis_step #(.COORD_BITS(COORD_BITS)) u_ax_x (
    .pos_in(position_x), .speed_in(speed_x), .frac_in(fraction_x),
    .pos_out(nx), .speed_out(dsx), .frac_out(fx)
  );
  cps_axis_step #(.COORD_BITS(COORD_BITS)) u_ax_y (
    .pos_in(position_y), .speed_in(speed_y), .frac_in(fraction_y),
    .pos_out(ny), .speed_out(dsy), .frac_out(fy)
  );
  cps_axis_step #(.COORD_BITS(COORD_BITS)) u_ax_z (
    .pos_in(position_z), .speed_in(speed_z_grav), .frac_in(fraction_z),
    .pos_out(nz), .speed_out(dsz), .frac_out(fz)
  );

  // Surface crossings, heights are nonnegative at coordinate widths of 16 bits or more
  assign land_ext  = COORD_BITS'(item.land_height);
  assign water_ext = COORD_BITS'(item.water_height);
  assign splash = (item.water_height != 15'd0) &&
                  ($signed(position_z) >= $signed(water_ext)) &&
                  ($signed(nz) <= $signed(water_ext));
  assign bounce = ($signed(position_z) >= $signed(land_ext)) &&
                  ($signed(nz) <= $signed(land_ext));

  // Animation counter, compared before wrap
  assign anim_sum = {1'b0, anim_counter} + {1'b0, cfg.frame_step};
  assign anim_adv = (anim_sum >= {1'b0, cfg.frame_limit}) ? 12'd0 : anim_sum[11:0];

  assign life_dec = lifetime - 9'd1;

  // Spawn seeding from the random word
  assign spawn_anim  = 12'({4'b0, item.random_word[7:0]} * CPS_FRAME_MUL);
  assign spawn_vprod = 11'({3'b0, item.random_word[30:23]} * CPS_VARIANT_MUL);
  assign spawn_px    = COORD_BITS'($signed(item.spawn_x));
  assign spawn_py    = COORD_BITS'($signed(item.spawn_y));
  assign spawn_pz    = COORD_BITS'($signed(item.spawn_z));

  // Next state and result
  always_comb begin
    live_flag_next    = live_flag;
    position_x_next   = position_x;
    position_y_next   = position_y;
    position_z_next   = position_z;
    speed_x_next      = speed_x;
    speed_y_next      = speed_y;
    speed_z_next      = speed_z;
    fraction_x_next   = fraction_x;
    fraction_y_next   = fraction_y;
    fraction_z_next   = fraction_z;
    lifetime_next     = lifetime;
    anim_counter_next = anim_counter;
    variant_next      = variant;
    result            = '0;

    case (item.opcode)
      OP_SPAWN: begin
        live_flag_next    = 1'b1;
        position_x_next   = spawn_px;
        position_y_next   = spawn_py;
        position_z_next   = spawn_pz;
        anim_counter_next = spawn_anim;
        lifetime_next     = {1'b0, cfg.life_base} + {2'b0, item.random_word[6:0]};
        variant_next      = spawn_vprod[10:8];
        speed_x_next      = {{14{item.random_word[15]}}, item.random_word[15:0], 2'b00};
        speed_y_next      = {{14{item.random_word[31]}}, item.random_word[31:16], 2'b00};
        speed_z_next      = {14'b0, item.random_word[23:8], 2'b00} + CPS_SPAWN_LIFT;
        fraction_x_next   = 16'd0;
        fraction_y_next   = 16'd0;
        fraction_z_next   = 16'd0;
        result.alive          = 1'b1;
        result.pos_x          = item.spawn_x;
        result.pos_y          = item.spawn_y;
        result.pos_z          = item.spawn_z;
        result.anim_frame     = spawn_anim;
        result.sprite_variant = spawn_vprod[10:8];
      end
      OP_TICK: begin
        if (live_flag) begin
          lifetime_next = life_dec;
          if (life_dec == 9'd0) begin
            // expiry: all-zero result
            live_flag_next = 1'b0;
          end else begin
            speed_x_next    = dsx;
            speed_y_next    = dsy;
            speed_z_next    = dsz;
            fraction_x_next = fx;
            fraction_y_next = fy;
            fraction_z_next = fz;
            if (splash) begin
              live_flag_next  = 1'b0;
              result.pos_x    = position_x[15:0];
              result.pos_y    = position_y[15:0];
              result.pos_z    = {1'b0, item.water_height};
              result.splashed = 1'b1;
            end else begin
              position_x_next   = nx;
              position_y_next   = ny;
              position_z_next   = bounce ? land_ext : nz;
              if (bounce) begin
                speed_z_next = 32'd0 - dsz;
              end
              anim_counter_next     = anim_adv;
              result.alive          = 1'b1;
              result.pos_x          = nx[15:0];
              result.pos_y          = ny[15:0];
              result.pos_z          = bounce ? {1'b0, item.land_height} : nz[15:0];
              result.anim_frame     = anim_adv;
              result.sprite_variant = variant;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_flag    <= 1'b0;
      position_x   <= '0;
      position_y   <= '0;
      position_z   <= '0;
      speed_x      <= '0;
      speed_y      <= '0;
      speed_z      <= '0;
      fraction_x   <= '0;
      fraction_y   <= '0;
      fraction_z   <= '0;
      lifetime     <= '0;
      anim_counter <= '0;
      variant      <= '0;
    end else if (fire) begin
      live_flag    <= live_flag_next;
      position_x   <= position_x_next;
      position_y   <= position_y_next;
      position_z   <= position_z_next;
      speed_x      <= speed_x_next;
      speed_y      <= speed_y_next;
      speed_z      <= speed_z_next;
      fraction_x   <= fraction_x_next;
      fraction_y   <= fraction_y_next;
      fraction_z   <= fraction_z_next;
      lifetime     <= lifetime_next;
      anim_counter <= anim_counter_next;
      variant      <= variant_next;
    end
  end

endmodule

[src/crash_particle_physics_step_core.sv]
// Top level of the debris particle step core: handshake, pipeline and probe.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer: a
//   spawn (opcode 0) or a tick (opcode 1) with terrain heights sampled at
//   the probe_x / probe_y of the previous result.
//   Output channel (out_valid / out_stall) carries exactly one result per
//   input item, in order.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are
//   registered directly; cfg_ready is always high. Write only while idle.
// Timing:
//   From input transfer to result valid, an item passes one input
//   register, then the state update and result register together.
//   Throughput is one item per cycle while no result is stalled; the particle
//   state register feeds back into the next item's update.
// Reset (rst, synchronous) clears the particle, both pipeline stages and
//   loads the default configuration.
// Stall: while out_stall holds a result, one more item is taken into the
//   input register; in_stall rises only when both stages are full.
module crash_particle_physics_step_core #(
  parameter int COORD_BITS = cps_pkg::CPS_COORD_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  opcode,
  input  logic signed [15:0]                    spawn_x,
  input  logic signed [15:0]                    spawn_y,
  input  logic signed [15:0]                    spawn_z,
  input  logic [31:0]                           random_word,
  input  logic [14:0]                           land_height,
  input  logic [14:0]                           water_height,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  alive,
  output logic signed [15:0]                    pos_x,
  output logic signed [15:0]                    pos_y,
  output logic signed [15:0]                    pos_z,
  output logic [11:0]                           anim_frame,
  output logic [2:0]                            sprite_variant,
  output logic                                  splashed,
  output logic signed [15:0]                    probe_x,
  output logic signed [15:0]                    probe_y,
  // configuration port
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cps_pkg::CPS_CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [cps_pkg::CPS_CFG_DATA_BITS-1:0] cfg_data
);
  import cps_pkg::*;

  cps_cfg_t              cfg;
  logic                  s1_valid;
  cps_item_t             s1_item;
  cps_result_t           out_result;
  cps_result_t           upd_result;
  logic                  adv;
  logic                  fire;
  logic                  accept;
  logic [COORD_BITS-1:0] position_x, position_y;
  logic [31:0]           speed_x, speed_y;
  logic [15:0]           fraction_x, fraction_y;
  logic [COORD_BITS-1:0] probe_px, probe_py;

  cps_cfg_regs u_cfg (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cfg_ready(cfg_ready), .cfg(cfg)
  );

  // Pipeline control: the result register frees up when empty or transferring
  assign adv      = !out_valid || !out_stall;
  assign fire     = s1_valid && adv;
  assign in_stall = s1_valid && !adv;
  assign accept   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.opcode       <= opcode;
      s1_item.spawn_x      <= spawn_x;
      s1_item.spawn_y      <= spawn_y;
      s1_item.spawn_z      <= spawn_z;
      s1_item.random_word  <= random_word;
      s1_item.land_height  <= land_height;
      s1_item.water_height <= water_height;
    end
  end

  cps_update #(.COORD_BITS(COORD_BITS)) u_update (
    .clk(clk), .rst(rst), .fire(fire), .item(s1_item), .cfg(cfg),
    .result(upd_result),
    .position_x(position_x), .position_y(position_y),
    .speed_x(speed_x), .speed_y(speed_y),
    .fraction_x(fraction_x), .fraction_y(fraction_y)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= upd_result;
    end
  end

  // Probe: where the next tick moves x and y, from the state just written.
  // The state only changes on fire, so it holds while a result is stalled.
  cps_axis_step #(.COORD_BITS(COORD_BITS)) u_probe_x (
    .pos_in(position_x), .speed_in(speed_x), .frac_in(fraction_x),
    .pos_out(probe_px), .speed_out(), .frac_out()
  );
  cps_axis_step #(.COORD_BITS(COORD_BITS)) u_probe_y (
    .pos_in(position_y), .speed_in(speed_y), .frac_in(fraction_y),
    .pos_out(probe_py), .speed_out(), .frac_out()
  );

  assign alive          = out_result.alive;
  assign pos_x          = out_result.pos_x;
  assign pos_y          = out_result.pos_y;
  assign pos_z          = out_result.pos_z;
  assign anim_frame     = out_result.anim_frame;
  assign sprite_variant = out_result.sprite_variant;
  assign splashed       = out_result.splashed;
  assign probe_x        = out_result.alive ? probe_px[15:0] : 16'd0;
  assign probe_y        = out_result.alive ? probe_py[15:0] : 16'd0;

endmodule

[src/cps_checker.sv]
// Port-level checker for the particle step core, bound to the top level.
`include "crash_particle_physics_step_core_defines.svh"

module cps_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic              alive,
  input logic signed [15:0] pos_x,
  input logic [11:0]       anim_frame,
  input logic [2:0]        sprite_variant,
  input logic              splashed,
  input logic signed [15:0] probe_x,
  input logic signed [15:0] probe_y
);

  // A splash always ends the particle
  `CPS_ASSERT_IMPLY(a_splash_dead, clk, rst, out_valid && splashed, !alive, "splash with alive set")

  // Dead results carry no probe, frame or variant
  `CPS_ASSERT_IMPLY(a_dead_clear, clk, rst, out_valid && !alive, probe_x == 16'sd0 && probe_y == 16'sd0 && anim_frame == 12'd0 && sprite_variant == 3'd0, "dead result with live fields")

  // Only five sprite sets exist
  `CPS_ASSERT_IMPLY(a_variant_range, clk, rst, out_valid, sprite_variant <= 3'd4, "sprite variant out of range")

  // A stalled result holds, probe included
  `CPS_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && out_stall, out_valid && $stable(pos_x) && $stable(probe_x) && $stable(alive), "stalled result changed")

endmodule

bind crash_particle_physics_step_core cps_checker u_cps_checker (.*);
